@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the timer queue.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/twsq_pkg.sv @@
// ----------------------------------------------------------------------------
// twsq_pkg
// Types and constants shared by the sorted timer wakeup queue modules.
// ----------------------------------------------------------------------------
package twsq_pkg;

	localparam int MAX_WAITERS_DEF = 16;
	localparam int RELEASE_LIMIT   = 16;
	localparam int TIME_W          = 64;
	localparam int TASK_W          = 8;
	localparam int DELAY_W         = 32;
	localparam int COUNT_W         = 5;
	localparam int IN_DATA_W       = 72;
	localparam int OUT_DATA_W      = 80;
	localparam int OUT_USER_W      = 2;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd10000;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	// One queue entry as held in the memory.
	typedef struct packed {
		logic [TIME_W-1:0] wake;
		logic [TASK_W-1:0] task_id;
	} entry_t;

	// One result item.
	typedef struct packed {
		logic              rel_valid;
		logic [TASK_W-1:0] task_id;
		status_t           status;
		logic [TIME_W-1:0] next_wake;
		logic [COUNT_W-1:0] count;
		logic              last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_REL_CHK,
		ST_REL_LD,
		ST_EMIT
	} state_t;

endpackage

@@ design/twsq_mem.sv @@
// ----------------------------------------------------------------------------
// twsq_mem
// Entry memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module twsq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  twsq_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output twsq_pkg::entry_t rdata
);
	import twsq_pkg::*;

	entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/twsq_ctrl.sv @@
// ----------------------------------------------------------------------------
// twsq_ctrl
// Sequencer of the timer queue: walks the circular entry memory to insert in
// order, pops due entries from the head and drives the result register.
// ----------------------------------------------------------------------------
module twsq_ctrl #(
	parameter int MAX_WAITERS = 16,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [twsq_pkg::DELAY_W-1:0]      cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  twsq_pkg::op_t                     in_op,
	input  logic [twsq_pkg::TASK_W-1:0]       in_task,
	input  logic [twsq_pkg::TIME_W-1:0]       in_now,
	output logic                              out_valid,
	input  logic                              out_ready,
	output twsq_pkg::result_t                 out_res,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output twsq_pkg::entry_t                  mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr,
	input  twsq_pkg::entry_t                  mem_rdata
);
	import twsq_pkg::*;

	localparam int RW = $clog2(RELEASE_LIMIT + 1);

	state_t              state_q, state_d;
	logic [DELAY_W-1:0]  delay_q;
	logic [AW-1:0]       hd_q;
	logic [CW-1:0]       cnt_q;
	logic [TIME_W-1:0]   head_wake_q;
	logic [TASK_W-1:0]   head_task_q;
	logic [TIME_W-1:0]   wake_q;
	logic [TASK_W-1:0]   task_q;
	logic [TIME_W-1:0]   now_q;
	logic [AW-1:0]       off_q;
	logic [RW-1:0]       nrel_q;
	result_t             res_q;
	logic                out_valid_q;
	result_t             out_q;

	logic                accept;
	logic                slot_free;
	logic                full;
	logic                ins_stop;
	logic                can_pop;
	logic [TIME_W-1:0]   wake_sum;

	// Physical address of a queue position counted from the head.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, hd} + {1'b0, off};
		if (sum >= (AW+1)'(MAX_WAITERS)) begin
			sum = sum - (AW+1)'(MAX_WAITERS);
		end
		return sum[AW-1:0];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = (cnt_q == CW'(MAX_WAITERS));
	assign ins_stop  = (mem_rdata.wake <= wake_q);
	assign can_pop   = (cnt_q != '0) && (head_wake_q <= now_q)
		&& (nrel_q != RW'(RELEASE_LIMIT));
	assign wake_sum  = in_now + TIME_W'(delay_q);

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Delay register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_wr_en) begin
			delay_q <= cfg_wr_data;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_op == OP_RELEASE) begin
						state_d = ST_REL_CHK;
					end else if (full) begin
						state_d = ST_EMIT;
					end else if (cnt_q == '0) begin
						state_d = ST_INS_PUT;
					end else begin
						state_d = ST_INS_CMP;
					end
				end
			end
			ST_INS_CMP: begin
				if (ins_stop) begin
					state_d = ST_EMIT;
				end else if (off_q == AW'(1)) begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT: state_d = ST_EMIT;
			ST_REL_CHK: state_d = can_pop ? ST_REL_LD : ST_EMIT;
			ST_REL_LD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					state_d = res_q.last ? ST_IDLE : ST_REL_CHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory access for the current state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = phys(hd_q, off_q);
		mem_wdata = '{wake: wake_q, task_id: task_q};
		mem_re    = 1'b0;
		mem_raddr = phys(hd_q, AW'(CW'(cnt_q - CW'(1))));
		unique case (state_q)
			ST_IDLE: begin
				mem_re = accept && (in_op == OP_INSERT) && !full && (cnt_q != '0);
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (!ins_stop) begin
					mem_wdata = mem_rdata;
					mem_re    = (off_q != AW'(1));
					mem_raddr = phys(hd_q, off_q - AW'(2));
				end
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = hd_q;
			end
			ST_REL_CHK: begin
				mem_re    = can_pop;
				mem_raddr = phys(hd_q, AW'(1));
			end
			ST_REL_LD, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ST_INS_CMP && ins_stop) || state_q == ST_INS_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == ST_REL_CHK && can_pop) begin
				cnt_q <= cnt_q - CW'(1);
				hd_q  <= phys(hd_q, AW'(1));
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				wake_q <= wake_sum;
				task_q <= in_task;
				now_q  <= in_now;
				off_q  <= AW'(cnt_q);
				nrel_q <= '0;
				res_q  <= '{rel_valid: 1'b0, task_id: '0, status: STATUS_FULL,
					next_wake: head_wake_q, count: COUNT_W'(cnt_q), last: 1'b1};
			end
			ST_INS_CMP: begin
				if (ins_stop) begin
					res_q.status    <= STATUS_OK;
					res_q.next_wake <= head_wake_q;
					res_q.count     <= COUNT_W'(cnt_q + CW'(1));
				end else begin
					off_q <= off_q - AW'(1);
				end
			end
			ST_INS_PUT: begin
				head_wake_q     <= wake_q;
				head_task_q     <= task_q;
				res_q.status    <= STATUS_OK;
				res_q.next_wake <= wake_q;
				res_q.count     <= COUNT_W'(cnt_q + CW'(1));
			end
			ST_REL_CHK: begin
				res_q.status <= STATUS_OK;
				if (can_pop) begin
					nrel_q          <= nrel_q + RW'(1);
					res_q.rel_valid <= 1'b1;
					res_q.task_id   <= head_task_q;
				end else begin
					res_q.rel_valid <= 1'b0;
					res_q.task_id   <= '0;
					res_q.next_wake <= (cnt_q != '0) ? head_wake_q : '0;
					res_q.count     <= COUNT_W'(cnt_q);
					res_q.last      <= 1'b1;
				end
			end
			ST_REL_LD: begin
				head_wake_q     <= mem_rdata.wake;
				head_task_q     <= mem_rdata.task_id;
				res_q.next_wake <= (cnt_q != '0) ? mem_rdata.wake : '0;
				res_q.count     <= COUNT_W'(cnt_q);
				res_q.last      <= (cnt_q == '0) || (nrel_q == RW'(RELEASE_LIMIT))
					|| (mem_rdata.wake > now_q);
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/timer_wakeup_sorted_queue_unit.sv @@
// Insert: walks the entries from the tail toward the head, one per step; a dropped insert goes straight to emit.
// Release: check and emit when nothing is due, else check, reload and emit per popped task.
// At most one item is in work; the next is taken as soon as its result is in the
// output register, and a stalled output holds the unit in its emit state. Reset clears count and
// head and sets the delay to 10000 us; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// timer_wakeup_sorted_queue_unit
// Queue of waiting tasks kept sorted by wakeup time in a circular memory.
// ----------------------------------------------------------------------------
module timer_wakeup_sorted_queue_unit #(
	parameter int MAX_WAITERS = twsq_pkg::MAX_WAITERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [twsq_pkg::DELAY_W-1:0]        cfg_wr_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// task_id [7:0], now_usec [71:8]
	input  logic [twsq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// op [0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// released_task [7:0], next_wakeup_usec [71:8], waiter_count [76:72], zero fill
	output logic [twsq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// released_valid [0], status [1]
	output logic [twsq_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                m_axis_tlast
);
	import twsq_pkg::*;

	localparam int AW = $clog2(MAX_WAITERS);
	localparam int CW = $clog2(MAX_WAITERS + 1);
	localparam int PAD_W = OUT_DATA_W - TASK_W - TIME_W - COUNT_W;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;
	result_t       res;
	op_t           in_op;

	assign in_op = op_t'(s_axis_tuser);

	// Sequencer and datapath.
	twsq_ctrl #(
		.MAX_WAITERS(MAX_WAITERS),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op(in_op),
		.in_task(s_axis_tdata[TASK_W-1:0]),
		.in_now(s_axis_tdata[TASK_W+TIME_W-1:TASK_W]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Entry storage.
	twsq_mem #(
		.DEPTH(MAX_WAITERS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Pack the result item onto the master side.
	assign m_axis_tdata = {{PAD_W{1'b0}}, res.count, res.next_wake, res.task_id};
	assign m_axis_tuser = {res.status, res.rel_valid};
	assign m_axis_tlast = res.last;

endmodule

@@ design/twsq_checker.sv @@
// ----------------------------------------------------------------------------
// twsq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twsq_checker #(
	parameter int MAX_WAITERS = twsq_pkg::MAX_WAITERS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [twsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [twsq_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                            m_axis_tlast
);
	import twsq_pkg::*;

	localparam bit COUNT_EXACT = (MAX_WAITERS < (1 << COUNT_W));

	// A result that releases no task always ends its item.
	`ASSERT_SAME(a_norel_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "non-release result without last")

	// A result without a released task carries task id zero.
	`ASSERT_SAME(a_norel_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[TASK_W-1:0] == '0, "idle result with nonzero task")

	// A dropped insert never releases a task.
	`ASSERT_SAME(a_full_norel, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "full status on a release result")

	// An empty queue reports a zero wakeup time.
	`ASSERT_SAME(a_empty_zero, COUNT_EXACT && m_axis_tvalid && (m_axis_tdata[TASK_W+TIME_W+COUNT_W-1:TASK_W+TIME_W] == '0), m_axis_tdata[TASK_W+TIME_W-1:TASK_W] == '0, "empty queue with nonzero wakeup")

	// A stalled result item holds.
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind timer_wakeup_sorted_queue_unit twsq_checker #(
	.MAX_WAITERS(MAX_WAITERS)
) u_twsq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
